// ===== src/led_pkg.sv =====
// ----------------------------------------------------------------------------
// Levenshtein edit distance: shared types
// Function codes of the input stream and the control group that moves
// along the systolic chain of cells.
// ----------------------------------------------------------------------------
package led_pkg;

	typedef enum logic [1:0] {
		FUNC_LOAD_A = 2'd0,
		FUNC_LOAD_B = 2'd1,
		FUNC_FINISH = 2'd2
	} func_t;

	localparam int SYM_W  = 8;
	localparam int DIST_W = 7;

	// Travels from one cell to the next every cycle while the row is not stopped.
	typedef struct packed {
		logic             sv;   // a second-string symbol is in this slot
		logic             tk;   // the finish token is in this slot
		logic [SYM_W-1:0] sym;
	} link_ctl_t;

	// Broadcast write of one first-string byte.
	typedef struct packed {
		logic             en;
		logic [SYM_W-1:0] sym;
	} load_t;

endpackage

// ===== src/led_cell.sv =====
// ----------------------------------------------------------------------------
// Levenshtein edit distance: one cell of the systolic row
// Holds one first-string byte and one entry of the cost row, updates the
// entry as a second-string symbol passes and picks up the distance when
// the finish token passes.
// ----------------------------------------------------------------------------
module led_cell #(
	parameter int IDX = 1,
	parameter int LW  = 7
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     en,
	input  led_pkg::load_t           ld,
	input  logic [LW-1:0]            ld_pos,
	input  logic [LW-1:0]            len,
	input  led_pkg::link_ctl_t       ctl_in,
	input  logic [LW-1:0]            new_in,
	input  logic [LW-1:0]            old_in,
	input  logic [LW-1:0]            td_in,
	output led_pkg::link_ctl_t       ctl_out,
	output logic [LW-1:0]            new_out,
	output logic [LW-1:0]            old_out,
	output logic [LW-1:0]            td_out
);
	import led_pkg::*;

	localparam logic [LW-1:0] IDX_L = LW'(IDX);
	localparam logic [LW-1:0] POS_L = LW'(IDX - 1);

	logic [SYM_W-1:0] ch_q;
	logic [LW-1:0]    c_q;
	link_ctl_t        ctl_q;
	logic [LW-1:0]    new_q;
	logic [LW-1:0]    old_q;
	logic [LW-1:0]    td_q;
	logic [LW:0]      via_diag;
	logic [LW:0]      via_up;
	logic [LW:0]      via_left;
	logic [LW:0]      best;

	always_comb begin
		via_diag = {1'b0, old_in} + {{LW{1'b0}}, (ch_q != ctl_in.sym)};
		via_up   = {1'b0, c_q} + {{LW{1'b0}}, 1'b1};
		via_left = {1'b0, new_in} + {{LW{1'b0}}, 1'b1};
		best     = via_diag;
		if (via_up < best) begin
			best = via_up;
		end
		if (via_left < best) begin
			best = via_left;
		end
	end

	// The token always trails the last symbol, so it
	// sees the final cost and then restores the entry to its cleared value.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_q   <= IDX_L;
			ctl_q <= '0;
		end else if (en) begin
			ctl_q <= ctl_in;
			if (ctl_in.sv) begin
				c_q <= best[LW-1:0];
			end else if (ctl_in.tk) begin
				c_q <= IDX_L;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			new_q <= best[LW-1:0];
			old_q <= c_q;
			td_q  <= (IDX_L == len) ? c_q : td_in;
		end
		if (ld.en && ld_pos == POS_L) begin
			ch_q <= ld.sym;
		end
	end

	assign ctl_out = ctl_q;
	assign new_out = new_q;
	assign old_out = old_q;
	assign td_out  = td_q;

endmodule

// ===== src/levenshtein_edit_distance.sv =====
// ----------------------------------------------------------------------------
// Levenshtein edit distance
// Systolic row of MAX_LEN cells; each cell keeps one first-string byte and
// one cost entry, and second-string symbols sweep through the row.
// ----------------------------------------------------------------------------
// Load items (func 0 and 1) are accepted back to back.
// A finish item (func 2) sends a token down the row: its result is registered
// as the token leaves the last cell, and no input is taken until it is valid.
// The token also restores every cost entry, so the next pair can start at once.
// Reset (arst_n low) clears lengths, overflow flag, cost row and output valid.
// ----------------------------------------------------------------------------
module levenshtein_edit_distance #(
	parameter int MAX_LEN = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] symbol
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [6:0] distance, [7] zero
	output logic        m_tuser    // [0] overflow
);
	import led_pkg::*;

	localparam int LW = $clog2(MAX_LEN + 1);
	localparam logic [LW-1:0] MAX_L = LW'(MAX_LEN);

	link_ctl_t     lk_ctl [0:MAX_LEN];
	logic [LW-1:0] lk_new [0:MAX_LEN];
	logic [LW-1:0] lk_old [0:MAX_LEN];
	logic [LW-1:0] lk_td  [0:MAX_LEN];

	logic [LW-1:0]     len1_q;
	logic [LW-1:0]     len2_q;
	logic              ovf_q;
	logic              busy_q;
	link_ctl_t         hd_ctl_q;
	logic [LW-1:0]     hd_new_q;
	logic [LW-1:0]     hd_old_q;
	logic [LW-1:0]     hd_td_q;
	logic              m_valid_q;
	logic [DIST_W-1:0] dist_q;
	logic              ovf_out_q;

	func_t             fn;
	logic              acc;
	logic              en;
	logic              tok_out;
	load_t             ld;
	logic [DIST_W-1:0] dist_sat;
	logic [MAX_LEN:0]  tk_vec;

	assign fn       = func_t'(s_tuser);
	assign acc      = s_tvalid && s_tready;
	assign s_tready = !busy_q;
	assign tok_out  = lk_ctl[MAX_LEN].tk;
	// The row only stops when the token is leaving and the result is still held.
	assign en       = !(tok_out && m_valid_q && !m_tready);

	assign ld.en  = acc && fn == FUNC_LOAD_A && len2_q == '0 && len1_q < MAX_L;
	assign ld.sym = s_tdata;

	always_comb begin
		if ({{DIST_W{1'b0}}, lk_td[MAX_LEN]} > (LW + DIST_W)'(2 ** DIST_W - 1)) begin
			dist_sat = '1;
		end else begin
			dist_sat = DIST_W'(lk_td[MAX_LEN]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len1_q    <= '0;
			len2_q    <= '0;
			ovf_q     <= 1'b0;
			busy_q    <= 1'b0;
			hd_ctl_q  <= '0;
			m_valid_q <= 1'b0;
		end else begin
			if (tok_out && en) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			if (en) begin
				hd_ctl_q.sv  <= acc && fn == FUNC_LOAD_B && len2_q < MAX_L;
				hd_ctl_q.tk  <= acc && fn == FUNC_FINISH;
				hd_ctl_q.sym <= s_tdata;
			end
			if (acc) begin
				unique case (fn)
					FUNC_LOAD_A: begin
						if (ld.en) begin
							len1_q <= len1_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					FUNC_LOAD_B: begin
						if (len2_q < MAX_L) begin
							len2_q <= len2_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					FUNC_FINISH: begin
						busy_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (tok_out && en) begin
				busy_q <= 1'b0;
				len1_q <= '0;
				len2_q <= '0;
				ovf_q  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hd_new_q <= len2_q + LW'(1);
			hd_old_q <= len2_q;
			hd_td_q  <= len2_q;
		end
		if (tok_out && en) begin
			dist_q    <= dist_sat;
			ovf_out_q <= ovf_q;
		end
	end

	assign lk_ctl[0] = hd_ctl_q;
	assign lk_new[0] = hd_new_q;
	assign lk_old[0] = hd_old_q;
	assign lk_td[0]  = hd_td_q;

	for (genvar i = 1; i <= MAX_LEN; i++) begin : g_cell
		led_cell #(
			.IDX (i),
			.LW  (LW)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.ld      (ld),
			.ld_pos  (len1_q),
			.len     (len1_q),
			.ctl_in  (lk_ctl[i-1]),
			.new_in  (lk_new[i-1]),
			.old_in  (lk_old[i-1]),
			.td_in   (lk_td[i-1]),
			.ctl_out (lk_ctl[i]),
			.new_out (lk_new[i]),
			.old_out (lk_old[i]),
			.td_out  (lk_td[i])
		);
	end

	for (genvar i = 0; i <= MAX_LEN; i++) begin : g_tk
		assign tk_vec[i] = lk_ctl[i].tk;
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {1'b0, dist_q};
	assign m_tuser  = ovf_out_q;

	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tk_vec))
		else $error("more than one finish token in the row");

	a_token_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> tk_vec == '0)
		else $error("finish token in the row while not busy");

	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		acc && fn == FUNC_FINISH |=> busy_q)
		else $error("finish transfer did not start the drain");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		len1_q <= MAX_L && len2_q <= MAX_L)
		else $error("string length beyond maximum");

	a_no_sym_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |=> !hd_ctl_q.sv)
		else $error("symbol entered the row behind the finish token");

endmodule
